@@ hw/rtl/w3sf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// w3sf_pkg
// Shared types, constants and sorting helpers of the 3x3 window smoothing
// filter.
// ----------------------------------------------------------------------------
package w3sf_pkg;

   // image geometry limits
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int SIZE_W     = 11;
   localparam int PIX_W      = 8;
   localparam int POS_W      = 10;

   // register reset values
   localparam logic [SIZE_W-1:0] LINE_WIDTH_RST   = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = SIZE_W'(480);
   localparam logic [SIZE_W-1:0] SIZE_MIN         = SIZE_W'(3);
   localparam logic [SIZE_W-1:0] WIDTH_MAX        = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] HEIGHT_MAX       = SIZE_W'(MAX_HEIGHT);

   // mean: floor(sum / 9) as (sum * ceil(2^16 / 9)) >> 16, exact for sum < 2304
   localparam int SUM_W      = 12;
   localparam int RECIP_W    = 13;
   localparam int RECIP_SH   = 16;
   localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((65536 + 8) / 9);
   localparam int PROD_W     = SUM_W + RECIP_W;

   // gaussian 1-2-1 kernel sum over 16
   localparam int GAUSS_SH   = 4;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_FILTER_MODE  = 2'd0,
      CSR_LINE_WIDTH   = 2'd1,
      CSR_FRAME_HEIGHT = 2'd2
   } csr_index_type;

   // filter modes (the unused code acts as mean)
   typedef enum logic [1:0] {
      MODE_MEAN   = 2'd0,
      MODE_MEDIAN = 2'd1,
      MODE_GAUSS  = 2'd2
   } mode_type;

   // one sorted triple of pixels
   typedef struct packed {
      logic [PIX_W-1:0] lo;
      logic [PIX_W-1:0] md;
      logic [PIX_W-1:0] hi;
   } triple_type;

   function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c);
      return max2(max2(a, b), c);
   endfunction

   function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c);
      return min2(min2(a, b), c);
   endfunction

   function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c);
      return max2(min2(a, b), min2(max2(a, b), c));
   endfunction

   function automatic triple_type sort3(input logic [PIX_W-1:0] a,
                                        input logic [PIX_W-1:0] b,
                                        input logic [PIX_W-1:0] c);
      triple_type t;
      t.lo = min3(a, b, c);
      t.md = med3(a, b, c);
      t.hi = max3(a, b, c);
      return t;
   endfunction

   // limit a size register to 3 .. maxv
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] maxv);
      if (v < SIZE_MIN) return SIZE_MIN;
      if (v > maxv)     return maxv;
      return v;
   endfunction

endpackage
`default_nettype wire

@@ hw/rtl/window3x3_smoothing_filter.sv @@
// A transferred pixel passes stage 1, stage 2, stage 3 and the output
// register before its result (if any) shows on rsp_tvalid; the four-stage
// pipeline takes one pixel per cycle unless rsp_tready stalls it, and the
// two line stores are read synchronously. Border pixels give no result.
// Reset clears counters, window registers, stage valids and the registers
// to their reset values; the line stores are not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// window3x3_smoothing_filter
// 3x3 mean / median / gaussian filter over a raster-order grey pixel stream,
// with two line stores in block memory and a 3x3 window in registers.
// ----------------------------------------------------------------------------
module window3x3_smoothing_filter
   import w3sf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_wdata,
   // pixel input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] pixel
   // filtered output
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,    // [7:0] filtered_value, [17:8] out_column,
                                          // [27:18] out_row, [31:28] zero
   output logic             rsp_tlast     // frame_last
);

   // configuration registers
   logic [1:0]        filter_mode_ff;
   logic [SIZE_W-1:0] line_width_ff;
   logic [SIZE_W-1:0] frame_height_ff;

   // position of the next pixel
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   // line stores
   logic [PIX_W-1:0]  upper_mem  [MAX_WIDTH];
   logic [PIX_W-1:0]  middle_mem [MAX_WIDTH];

   // stage 1: pixel and line store read data
   logic              s1_v_ff;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic [PIX_W-1:0]  s1_top_ff;
   logic [PIX_W-1:0]  s1_mid_ff;
   logic [COL_W-1:0]  s1_col_ff;
   logic [ROW_W-1:0]  s1_row_ff;
   logic              s1_res_ff;
   logic              s1_last_ff;

   // window columns, oldest first: top, middle, bottom of each column
   logic [PIX_W-1:0]  wc_ff [6];

   // stage 2: full 3x3 window in raster order
   logic              s2_v_ff;
   logic [PIX_W-1:0]  s2_win_ff [9];
   logic [POS_W-1:0]  s2_col_ff;
   logic [POS_W-1:0]  s2_row_ff;
   logic              s2_last_ff;

   // stage 3: sorted rows and sums
   logic              s3_v_ff;
   triple_type        s3_tri_ff [3];
   logic [SUM_W-1:0]  s3_sum_ff;
   logic [SUM_W-1:0]  s3_gsum_ff;
   logic [POS_W-1:0]  s3_col_ff;
   logic [POS_W-1:0]  s3_row_ff;
   logic              s3_last_ff;

   // output register
   logic              out_v_ff;
   logic [PIX_W-1:0]  out_val_ff, out_val_in;
   logic [POS_W-1:0]  out_col_ff;
   logic [POS_W-1:0]  out_row_ff;
   logic              out_last_ff;

   logic              rdy_out, rdy_s3, rdy_s2, rdy_s1;
   logic              req_xfer, s1_move;
   logic [SIZE_W-1:0] width_use, height_use;
   logic [SIZE_W-1:0] col_next, row_next;
   logic              pos_last;
   logic [PROD_W-1:0] mean_prod;
   logic [SUM_W-1:0]  sum9, gsum;

   // stall chain: a stage loads when it is empty or moves on
   always_comb begin
      rdy_out = !out_v_ff || rsp_tready;
      rdy_s3  = !s3_v_ff  || rdy_out;
      rdy_s2  = !s2_v_ff  || rdy_s3;
      rdy_s1  = !s1_v_ff  || rdy_s2;
   end

   assign req_tready = rdy_s1;
   assign req_xfer   = req_tvalid && rdy_s1;
   assign s1_move    = s1_v_ff && rdy_s2;
   assign csr_ready  = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff  <= MODE_MEAN;
         line_width_ff   <= LINE_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FILTER_MODE:  filter_mode_ff  <= csr_wdata[1:0];
            CSR_LINE_WIDTH:   line_width_ff   <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // position counters with wrap at line and frame end
   always_comb begin
      width_use  = clamp_size(line_width_ff, WIDTH_MAX);
      height_use = clamp_size(frame_height_ff, HEIGHT_MAX);
      col_next   = SIZE_W'(col_ff) + SIZE_W'(1);
      row_next   = SIZE_W'(row_ff) + SIZE_W'(1);
      pos_last   = (SIZE_W'(col_ff) == width_use - SIZE_W'(1)) &&
                   (SIZE_W'(row_ff) == height_use - SIZE_W'(1));
      col_in     = col_ff;
      row_in     = row_ff;
      if (col_next >= width_use) begin
         col_in = '0;
         row_in = (row_next >= height_use) ? '0 : row_next[ROW_W-1:0];
      end else begin
         col_in = col_next[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_xfer) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line store read on transfer, write back as the item leaves stage 1;
   // the same entry is read again at least three pixels later, so the
   // write has always landed first
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_top_ff <= upper_mem[col_ff];
      end
      if (s1_move) begin
         upper_mem[s1_col_ff] <= s1_mid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_mid_ff <= middle_mem[col_ff];
      end
      if (s1_move) begin
         middle_mem[s1_col_ff] <= s1_pix_ff;
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_pix_ff  <= req_tdata;
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
         s1_res_ff  <= (col_ff >= COL_W'(2)) && (row_ff >= ROW_W'(2));
         s1_last_ff <= pos_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (rdy_s1) begin
         s1_v_ff <= req_tvalid;
      end
   end

   // window shift, one column per pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) wc_ff[i] <= '0;
      end else if (s1_move) begin
         wc_ff[0] <= wc_ff[3];
         wc_ff[1] <= wc_ff[4];
         wc_ff[2] <= wc_ff[5];
         wc_ff[3] <= s1_top_ff;
         wc_ff[4] <= s1_mid_ff;
         wc_ff[5] <= s1_pix_ff;
      end
   end

   // stage 2: window snapshot, border pixels dropped here
   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_win_ff[0] <= wc_ff[0];
         s2_win_ff[1] <= wc_ff[3];
         s2_win_ff[2] <= s1_top_ff;
         s2_win_ff[3] <= wc_ff[1];
         s2_win_ff[4] <= wc_ff[4];
         s2_win_ff[5] <= s1_mid_ff;
         s2_win_ff[6] <= wc_ff[2];
         s2_win_ff[7] <= wc_ff[5];
         s2_win_ff[8] <= s1_pix_ff;
         s2_col_ff    <= POS_W'(s1_col_ff - COL_W'(1));
         s2_row_ff    <= POS_W'(s1_row_ff - ROW_W'(1));
         s2_last_ff   <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (rdy_s2) begin
         s2_v_ff <= s1_v_ff && s1_res_ff;
      end
   end

   // stage 3: row sorts and kernel sums
   always_comb begin
      sum9 = '0;
      for (int i = 0; i < 9; i++) sum9 = sum9 + SUM_W'(s2_win_ff[i]);
      gsum = SUM_W'(s2_win_ff[0]) + SUM_W'(s2_win_ff[2]) +
             SUM_W'(s2_win_ff[6]) + SUM_W'(s2_win_ff[8]) +
             ((SUM_W'(s2_win_ff[1]) + SUM_W'(s2_win_ff[3]) +
               SUM_W'(s2_win_ff[5]) + SUM_W'(s2_win_ff[7])) << 1) +
             (SUM_W'(s2_win_ff[4]) << 2);
   end

   always_ff @(posedge clock) begin
      if (s2_v_ff && rdy_s3) begin
         for (int r = 0; r < 3; r++) begin
            s3_tri_ff[r] <= sort3(s2_win_ff[3*r], s2_win_ff[3*r+1], s2_win_ff[3*r+2]);
         end
         s3_sum_ff  <= sum9;
         s3_gsum_ff <= gsum;
         s3_col_ff  <= s2_col_ff;
         s3_row_ff  <= s2_row_ff;
         s3_last_ff <= s2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (rdy_s3) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   // final stage: mean by reciprocal, median from the sorted rows, gaussian shift
   always_comb begin
      mean_prod = PROD_W'(s3_sum_ff) * PROD_W'(RECIP_9);
      case (filter_mode_ff)
         MODE_MEDIAN: out_val_in = med3(
               max3(s3_tri_ff[0].lo, s3_tri_ff[1].lo, s3_tri_ff[2].lo),
               med3(s3_tri_ff[0].md, s3_tri_ff[1].md, s3_tri_ff[2].md),
               min3(s3_tri_ff[0].hi, s3_tri_ff[1].hi, s3_tri_ff[2].hi));
         MODE_GAUSS:  out_val_in = s3_gsum_ff[GAUSS_SH +: PIX_W];
         default:     out_val_in = mean_prod[RECIP_SH +: PIX_W];
      endcase
   end

   always_ff @(posedge clock) begin
      if (s3_v_ff && rdy_out) begin
         out_val_ff  <= out_val_in;
         out_col_ff  <= s3_col_ff;
         out_row_ff  <= s3_row_ff;
         out_last_ff <= s3_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (rdy_out) begin
         out_v_ff <= s3_v_ff;
      end
   end

   // result port
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'b0000, out_row_ff, out_col_ff, out_val_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   // the last pixel of a frame always lies inside the border
   a_last_is_interior: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s1_last_ff |-> s1_res_ff)
      else $error("frame end marked on a border pixel");

   // a new read never hits the entry still waiting for its write back
   a_no_store_hazard: assert property (@(posedge clock) disable iff (reset)
      req_xfer && s1_v_ff |-> col_ff != s1_col_ff)
      else $error("line store read and pending write share an entry");

   // an empty output register lets the whole pipeline move
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !out_v_ff |-> req_tready)
      else $error("input stalled with an empty output register");

   // results only ever carry interior positions
   a_interior_position: assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> (out_col_ff != '0) && (out_row_ff != '0))
      else $error("result for a border position");
`endif

endmodule
`default_nettype wire

@@ tb/w3sf_checker.sv @@
// ----------------------------------------------------------------------------
// w3sf_checker
// Watches the configuration, pixel and result channels of the smoothing
// filter. Keeps its own line stores, window columns and raster position,
// works out the smoothed value for every interior pixel and compares each
// result transfer, field by field, with the oldest value still due.
// ----------------------------------------------------------------------------
module w3sf_checker
   import w3sf_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [10:0] csr_wdata,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,    // [7:0] pixel
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,    // [7:0] filtered_value, [17:8] out_column,
                                          // [27:18] out_row, [31:28] zero
   input  wire logic        rsp_tlast,    // frame_last
   output int               mismatch_count,
   output int               results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MIN_SIZE     = 3;
   localparam int REPORT_LIMIT = 10;

   typedef logic [8:0][PIX_W-1:0] window_type;

   typedef struct packed {
      logic [PIX_W-1:0] value;
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
      logic             frame_end;
   } smoothed_type;

   smoothed_type smoothed_due[$];

   // own copy of the filter state
   logic [PIX_W-1:0]  upper_line  [MAX_WIDTH];
   logic [PIX_W-1:0]  middle_line [MAX_WIDTH];
   logic [PIX_W-1:0]  win_cols    [6];
   int                col_pos;
   int                row_pos;
   logic [1:0]        mode_reg;
   logic [SIZE_W-1:0] width_reg;
   logic [SIZE_W-1:0] height_reg;

   // size register as the filter uses it
   function automatic int size_in_use(input logic [SIZE_W-1:0] v, input int limit);
      int n;
      n = int'(v);
      if (n < MIN_SIZE) n = MIN_SIZE;
      if (n > limit) n = limit;
      return n;
   endfunction

   // window is in raster order, element 4 is the centre
   function automatic logic [PIX_W-1:0] smooth_window(input logic [1:0] mode,
                                                      input window_type px);
      logic [PIX_W-1:0] order [9];
      logic [PIX_W-1:0] key;
      int total;
      int i;
      int j;
      total = 0;
      case (mode)
         MODE_MEDIAN: begin
            // insertion sort, fifth smallest is the median
            for (i = 0; i < 9; i++) begin
               key = px[i];
               j = i;
               while (j > 0 && order[j-1] > key) begin
                  order[j] = order[j-1];
                  j--;
               end
               order[j] = key;
            end
            return order[4];
         end
         MODE_GAUSS: begin
            // corners weigh 1, edges 2, centre 4
            for (i = 0; i < 9; i++)
               total += int'(px[i]) * ((i == 4) ? 4 : (i % 2 == 1) ? 2 : 1);
            return PIX_W'(total / 16);
         end
         default: begin
            // mean, also for the spare mode code
            for (i = 0; i < 9; i++)
               total += int'(px[i]);
            return PIX_W'(total / 9);
         end
      endcase
   endfunction

   task automatic flag_field(input string field, input int want_v, input int got_v);
      if (want_v != got_v) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT)
            $display("%0t ns: %s mismatch, expected %0d, got %0d",
                     $time, field, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin : watch
      smoothed_type     want;
      window_type       win;
      logic [PIX_W-1:0] above;
      logic [PIX_W-1:0] beside;
      logic [PIX_W-1:0] incoming;
      int               w_eff;
      int               h_eff;
      if (reset) begin
         foreach (upper_line[k]) begin
            upper_line[k]  = '0;
            middle_line[k] = '0;
         end
         foreach (win_cols[k])
            win_cols[k] = '0;
         col_pos    = 0;
         row_pos    = 0;
         mode_reg   = MODE_MEAN;
         width_reg  = LINE_WIDTH_RST;
         height_reg = FRAME_HEIGHT_RST;
         smoothed_due.delete();
      end else begin
         // result transfer against the oldest value due
         if (rsp_tvalid && rsp_tready) begin
            if (smoothed_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t ns: result with nothing due, value %0d column %0d row %0d",
                           $time, rsp_tdata[7:0], rsp_tdata[17:8], rsp_tdata[27:18]);
            end else begin
               want = smoothed_due.pop_front();
               flag_field("filtered_value", want.value,     rsp_tdata[7:0]);
               flag_field("out_column",     want.column,    rsp_tdata[17:8]);
               flag_field("out_row",        want.row,       rsp_tdata[27:18]);
               flag_field("padding",        0,              rsp_tdata[31:28]);
               flag_field("frame_last",     want.frame_end, rsp_tlast);
            end
         end

         // pixel transfer: advance the window and the line stores
         if (req_tvalid && req_tready) begin
            w_eff    = size_in_use(width_reg, MAX_WIDTH);
            h_eff    = size_in_use(height_reg, MAX_HEIGHT);
            above    = upper_line[col_pos];
            beside   = middle_line[col_pos];
            incoming = req_tdata;
            if (col_pos >= 2 && row_pos >= 2) begin
               win = {incoming, win_cols[5], win_cols[2],
                      beside,   win_cols[4], win_cols[1],
                      above,    win_cols[3], win_cols[0]};
               want.value     = smooth_window(mode_reg, win);
               want.column    = POS_W'(col_pos - 1);
               want.row       = POS_W'(row_pos - 1);
               want.frame_end = (col_pos == w_eff - 1) && (row_pos == h_eff - 1);
               smoothed_due.push_back(want);
            end
            win_cols[0] = win_cols[3];
            win_cols[1] = win_cols[4];
            win_cols[2] = win_cols[5];
            win_cols[3] = above;
            win_cols[4] = beside;
            win_cols[5] = incoming;
            upper_line[col_pos]  = beside;
            middle_line[col_pos] = incoming;
            // a position at or past a shrunk size wraps at the next pixel
            if (col_pos + 1 >= w_eff) begin
               col_pos = 0;
               row_pos = (row_pos + 1 >= h_eff) ? 0 : row_pos + 1;
            end else begin
               col_pos++;
            end
         end

         // register write
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FILTER_MODE:  mode_reg   = csr_wdata[1:0];
               CSR_LINE_WIDTH:   width_reg  = csr_wdata;
               CSR_FRAME_HEIGHT: height_reg = csr_wdata;
               default:          ;
            endcase
         end
      end
      results_due <= smoothed_due.size();
   end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the 3x3 window smoothing filter: a first line at the reset
// sizes and mode, a line shrunk mid-frame, a clamped spare-mode frame, short
// gaussian and median frames, a long result stall, and random frames and
// partial runs with size changes between them. Checking is by w3sf_checker.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import w3sf_pkg::*;

   localparam int          RESET_CYCLES = 11;
   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          RANDOM_ITEMS = 500;
   localparam int          SHRUNK_WIDTH = 3;
   localparam logic [1:0]  MODE_SPARE   = 2'd3;
   localparam logic [1:0]  CSR_SPARE    = 2'd3;

   // pixels of the directed median frame, first pixel lowest
   localparam logic [8:0][7:0] MEDIAN_PIXELS = {8'd99, 8'd255, 8'd0, 8'd13, 8'd200,
                                                8'd7, 8'd255, 8'd128, 8'd0};

   logic        clock;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = CSR_FILTER_MODE;
   logic [10:0] csr_wdata  = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        hold_go    = 1'b0;
   logic        req_gaps   = 1'b1;
   logic        rsp_gaps   = 1'b1;
   int          mismatches;
   int          waiting;

   // stimulus-side raster position and sizes in use
   int          cur_w;
   int          cur_h;
   int          pos_col;
   int          pos_row;
   int          pixels_sent;
   int          style;
   int          base_level;

   window3x3_smoothing_filter dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   w3sf_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatches),
      .results_due    (waiting)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // overall cycle limit
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("window3x3_smoothing_filter test failed");
      $finish;
   end

   // result side: random stall after each transfer, one long hold-off
   initial begin : result_sink
      int   stall_left;
      int   hold_left;
      logic hold_used;
      stall_left = 0;
      hold_left  = 0;
      hold_used  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready)
            stall_left = rsp_gaps ? $urandom_range(0, 7) : 0;
         if (hold_go && !hold_used) begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic int size_in_use(input int v);
      if (v < 3) return 3;
      if (v > MAX_WIDTH) return MAX_WIDTH;
      return v;
   endfunction

   function automatic logic [7:0] next_pixel();
      int v;
      case (style)
         0:       v = $urandom_range(0, 255);
         1:       v = $urandom_range(0, 1) ? 255 : 0;
         default: begin
            // gentle texture around a level
            v = base_level + $urandom_range(0, 31) - 16;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
         end
      endcase
      return 8'(v);
   endfunction

   // one pixel transfer, valid stays high when no gap follows
   task automatic send_pixel(input logic [7:0] p);
      int gap;
      gap = req_gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= p;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      if (pos_col + 1 >= cur_w) begin
         pos_col = 0;
         pos_row = (pos_row + 1 >= cur_h) ? 0 : pos_row + 1;
      end else begin
         pos_col++;
      end
   endtask

   task automatic send_run(input int n);
      repeat (n) send_pixel(next_pixel());
   endtask

   // at least one pixel, on until the next frame starts
   task automatic run_to_frame_end();
      do send_pixel(next_pixel()); while (pos_col != 0 || pos_row != 0);
   endtask

   // input idle, every result out, pipeline empty
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (waiting != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input int value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= 11'(value);
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [1:0] mode, input int w, input int h);
      wait_quiet();
      write_reg(CSR_FILTER_MODE, mode);
      write_reg(CSR_LINE_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      if ($urandom_range(0, 3) == 0)
         write_reg(CSR_SPARE, $urandom_range(0, 2047));
      csr_valid <= 1'b0;
      cur_w = size_in_use(w);
      cur_h = size_in_use(h);
   endtask

   initial begin : stimulus
      int         phase;
      int         random_base;
      int         w_wr;
      int         h_wr;
      logic [1:0] mode_wr;
      cur_w       = int'(LINE_WIDTH_RST);
      cur_h       = int'(FRAME_HEIGHT_RST);
      pos_col     = 0;
      pos_row     = 0;
      pixels_sent = 0;
      style       = 0;
      base_level  = 128;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset sizes and mode: one whole line and a few pixels of the next
      send_run(cur_w + 5);

      // narrow the line mid-frame, reset mode and height still in use
      wait_quiet();
      write_reg(CSR_LINE_WIDTH, SHRUNK_WIDTH);
      csr_valid <= 1'b0;
      cur_w = SHRUNK_WIDTH;
      send_run(4);

      // clamped 3x3 frame, spare mode as mean, row past the new height wraps
      configure(MODE_SPARE, 0, 1);
      run_to_frame_end();
      repeat (9) send_pixel(8'd255);

      // gaussian at its largest weighted sum
      configure(MODE_GAUSS, 3, 3);
      repeat (9) send_pixel(8'd255);

      // median with duplicates at both extremes
      configure(MODE_MEDIAN, 3, 3);
      for (int i = 0; i < 9; i++)
         send_pixel(MEDIAN_PIXELS[i]);

      // random phases
      random_base = pixels_sent;
      phase = 0;
      while (pixels_sent - random_base < RANDOM_ITEMS) begin
         req_gaps   = ($urandom_range(0, 3) != 0);
         rsp_gaps   = ($urandom_range(0, 3) != 0);
         style      = $urandom_range(0, 2);
         base_level = $urandom_range(0, 255);
         mode_wr    = 2'($urandom_range(0, 3));
         if (phase == 0) begin
            // long result stall while pixels keep coming, input must back up
            configure(mode_wr, 20, 12);
            req_gaps = 1'b0;
            hold_go <= 1'b1;
            run_to_frame_end();
         end else begin
            if (pos_col == 0 && pos_row == 0) begin
               w_wr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
               h_wr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
            end else begin
               // mid-frame the width may only shrink, so no unwritten column is read
               w_wr = $urandom_range(0, cur_w);
               h_wr = $urandom_range(0, 12);
            end
            configure(mode_wr, w_wr, h_wr);
            if ($urandom_range(0, 9) < 7)
               run_to_frame_end();
            else
               send_run($urandom_range(1, 60));
         end
         phase++;
      end

      // drain and verdict
      wait_quiet();
      if (mismatches == 0 && waiting == 0)
         $display("window3x3_smoothing_filter test passed");
      else
         $display("window3x3_smoothing_filter test failed");
      $finish;
   end

endmodule

@@ window3x3_smoothing_filter.f @@
hw/rtl/w3sf_pkg.sv
hw/rtl/window3x3_smoothing_filter.sv
tb/w3sf_checker.sv
tb/tb_top.sv
